// File: rtl/config_text_tokenizer_macros.svh
`ifndef CONFIG_TEXT_TOKENIZER_MACROS_SVH
`define CONFIG_TEXT_TOKENIZER_MACROS_SVH

// Implication checked in the same cycle, sampled on the rising clock edge.
`define CTT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked in the cycle after the antecedent.
`define CTT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/ctt_pkg.sv
package ctt_pkg;

  localparam int unsigned LINE_BITS_DEF = 16;
  localparam int unsigned LINE_OUT_W    = 16;
  localparam int unsigned MAX_RES       = 3;

  typedef enum logic [1:0] {
    RK_TEXT,
    RK_END,
    RK_ERROR
  } rk_e;

  typedef enum logic [3:0] {
    TK_STR,
    TK_NAME,
    TK_NUMBER,
    TK_QUOTED,
    TK_EQUALS,
    TK_COLON,
    TK_OPEN,
    TK_CLOSE,
    TK_EOF
  } tk_e;

  typedef enum logic [2:0] {
    ER_NONE,
    ER_NUMBER,
    ER_HEX,
    ER_UNTERM,
    ER_INVALID
  } err_e;

  typedef struct packed {
    rk_e        kind;
    tk_e        tok;
    logic [7:0] data;
    err_e       err;
  } res_t;

  typedef struct packed {
    logic [1:0]                  cnt;
    res_t [MAX_RES-1:0]          res;
    logic [LINE_OUT_W-1:0]       line;
  } batch_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return is_digit(c) || ((c >= "a") && (c <= "f")) || ((c >= "A") && (c <= "F"));
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] t;
    if (is_digit(c)) begin
      t = c - 8'h30;
    end else if ((c >= "a") && (c <= "f")) begin
      t = c - 8'h57;
    end else begin
      t = c - 8'h37;
    end
    return t[3:0];
  endfunction

  function automatic logic is_word(input logic [7:0] c);
    logic r;
    r = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || is_digit(c);
    case (c) inside
      "-", "+", "~", "!", "@", "$", "(", ")", "%", "^", "&", "*", "_", "|", 8'h5C,
      ";", "<", ">", ",", "?", "/", "[", "]", ".": r = 1'b1;
      default: ;
    endcase
    return r;
  endfunction

  function automatic res_t mk_text(input tk_e tok, input logic [7:0] data);
    res_t r;
    r.kind = RK_TEXT;
    r.tok  = tok;
    r.data = data;
    r.err  = ER_NONE;
    return r;
  endfunction

  function automatic res_t mk_end(input tk_e tok);
    res_t r;
    r.kind = RK_END;
    r.tok  = tok;
    r.data = 8'h00;
    r.err  = ER_NONE;
    return r;
  endfunction

  function automatic res_t mk_err(input err_e code);
    res_t r;
    r.kind = RK_ERROR;
    r.tok  = TK_STR;
    r.data = 8'h00;
    r.err  = code;
    return r;
  endfunction

endpackage

// File: rtl/ctt_scan.sv
module ctt_scan import ctt_pkg::*; #(
  parameter int unsigned LineBits = LINE_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       fire_i,
  input  logic [7:0] byte_i,
  input  logic       eoi_i,
  output batch_t     batch_o
);

  typedef enum logic [3:0] {
    M_IDLE, M_COMMENT, M_NAME, M_STR, M_NUM1, M_NUM2, M_NUM3, M_NUM4, M_NUM5,
    M_MINUS, M_QSTR, M_QESC, M_HEX1, M_HEX2, M_ERR
  } mode_e;

  typedef struct packed {
    mode_e      next;
    logic       again;
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
    logic       line_inc;
    logic [3:0] hex;
  } pass_t;

  function automatic pass_t scan_pass(input mode_e m, input logic [7:0] c,
                                      input logic [3:0] hex);
    pass_t p;
    p.next     = m;
    p.again    = 1'b0;
    p.n        = 2'd0;
    p.r0       = mk_end(TK_STR);
    p.r1       = mk_end(TK_STR);
    p.line_inc = 1'b0;
    p.hex      = hex;
    unique case (m)
      M_IDLE: begin
        case (c) inside
          "#": p.next = M_COMMENT;
          "=": begin p.r0 = mk_end(TK_EQUALS); p.n = 2'd1; end
          ":": begin p.r0 = mk_end(TK_COLON); p.n = 2'd1; end
          "{": begin p.r0 = mk_end(TK_OPEN); p.n = 2'd1; end
          "}": begin p.r0 = mk_end(TK_CLOSE); p.n = 2'd1; end
          8'h22: p.next = M_QSTR;
          "+": begin p.r0 = mk_text(TK_NUMBER, c); p.n = 2'd1; p.next = M_NUM1; end
          ".": begin
            p.r0 = mk_text(TK_NUMBER, "0");
            p.r1 = mk_text(TK_NUMBER, ".");
            p.n = 2'd2;
            p.next = M_NUM2;
          end
          "-": p.next = M_MINUS;
          8'h0A: p.line_inc = 1'b1;
          8'h20, 8'h09, 8'h0B, 8'h0C, 8'h0D: ;
          default: begin
            p.n = 2'd1;
            if (is_digit(c)) begin
              p.r0 = mk_text(TK_NUMBER, c);
              p.next = M_NUM1;
            end else if ((c == "$") || (c == 8'h5C)) begin
              p.r0 = mk_text(TK_STR, c);
              p.next = M_STR;
            end else if (is_word(c)) begin
              p.r0 = mk_text(TK_NAME, c);
              p.next = M_NAME;
            end else begin
              p.r0 = mk_err(ER_INVALID);
              p.next = M_ERR;
            end
          end
        endcase
      end
      M_COMMENT: begin
        if (c == 8'h0A) begin
          p.next = M_IDLE;
          p.again = 1'b1;
        end
      end
      M_NAME: begin
        p.n = 2'd1;
        if ((c == "$") || (c == 8'h5C)) begin
          p.r0 = mk_text(TK_STR, c);
          p.next = M_STR;
        end else if (is_word(c)) begin
          p.r0 = mk_text(TK_NAME, c);
        end else begin
          p.r0 = mk_end(TK_NAME);
          p.next = M_IDLE;
          p.again = 1'b1;
        end
      end
      M_STR: begin
        p.n = 2'd1;
        if (is_word(c)) begin
          p.r0 = mk_text(TK_STR, c);
        end else begin
          p.r0 = mk_end(TK_STR);
          p.next = M_IDLE;
          p.again = 1'b1;
        end
      end
      M_NUM1: begin
        p.n = 2'd1;
        if (c == ".") begin
          p.r0 = mk_text(TK_NUMBER, c);
          p.next = M_NUM2;
        end else if ((c == "e") || (c == "E")) begin
          p.r0 = mk_text(TK_NUMBER, "e");
          p.next = M_NUM4;
        end else if (is_digit(c)) begin
          p.r0 = mk_text(TK_NUMBER, c);
        end else begin
          p.r0 = mk_end(TK_NUMBER);
          p.next = M_IDLE;
          p.again = 1'b1;
        end
      end
      M_NUM2: begin
        p.n = 2'd1;
        if (is_digit(c)) begin
          p.r0 = mk_text(TK_NUMBER, c);
          p.next = M_NUM3;
        end else begin
          p.r0 = mk_err(ER_NUMBER);
          p.next = M_ERR;
        end
      end
      M_NUM3: begin
        p.n = 2'd1;
        if (is_digit(c)) begin
          p.r0 = mk_text(TK_NUMBER, c);
        end else if ((c == "e") || (c == "E")) begin
          p.r0 = mk_text(TK_NUMBER, c);
          p.next = M_NUM4;
        end else begin
          p.r0 = mk_end(TK_NUMBER);
          p.next = M_IDLE;
          p.again = 1'b1;
        end
      end
      M_NUM4: begin
        p.n = 2'd1;
        if ((c == "+") || (c == "-") || is_digit(c)) begin
          p.r0 = mk_text(TK_NUMBER, c);
          p.next = M_NUM5;
        end else begin
          p.r0 = mk_err(ER_NUMBER);
          p.next = M_ERR;
        end
      end
      M_NUM5: begin
        p.n = 2'd1;
        if (is_digit(c)) begin
          p.r0 = mk_text(TK_NUMBER, c);
        end else begin
          p.r0 = mk_end(TK_NUMBER);
          p.next = M_IDLE;
          p.again = 1'b1;
        end
      end
      M_MINUS: begin
        if (is_digit(c)) begin
          p.r0 = mk_text(TK_NUMBER, "-");
          p.r1 = mk_text(TK_NUMBER, c);
          p.n = 2'd2;
          p.next = M_NUM1;
        end else begin
          p.r0 = mk_text(TK_STR, "-");
          p.n = 2'd1;
          p.next = M_STR;
          p.again = 1'b1;
        end
      end
      M_QSTR: begin
        if (c == 8'h22) begin
          p.r0 = mk_end(TK_QUOTED);
          p.n = 2'd1;
          p.next = M_IDLE;
        end else if (c == 8'h0A) begin
          p.line_inc = 1'b1;
        end else if (c == 8'h5C) begin
          p.next = M_QESC;
        end else begin
          p.r0 = mk_text(TK_QUOTED, c);
          p.n = 2'd1;
        end
      end
      M_QESC: begin
        p.next = M_QSTR;
        p.n = 2'd1;
        case (c)
          "a": p.r0 = mk_text(TK_QUOTED, 8'h07);
          "b": p.r0 = mk_text(TK_QUOTED, 8'h08);
          "e": p.r0 = mk_text(TK_QUOTED, 8'h1B);
          "f": p.r0 = mk_text(TK_QUOTED, 8'h0C);
          "n": p.r0 = mk_text(TK_QUOTED, 8'h0A);
          "r": p.r0 = mk_text(TK_QUOTED, 8'h0D);
          "t": p.r0 = mk_text(TK_QUOTED, 8'h09);
          "v": p.r0 = mk_text(TK_QUOTED, 8'h0B);
          "x": begin p.n = 2'd0; p.next = M_HEX1; end
          default: p.r0 = mk_text(TK_QUOTED, c);
        endcase
      end
      M_HEX1: begin
        if (is_hex(c)) begin
          p.hex = hex_val(c);
          p.next = M_HEX2;
        end else begin
          p.r0 = mk_err(ER_HEX);
          p.n = 2'd1;
          p.next = M_ERR;
        end
      end
      M_HEX2: begin
        p.n = 2'd1;
        if (is_hex(c)) begin
          p.r0 = mk_text(TK_QUOTED, {hex, hex_val(c)});
          p.next = M_QSTR;
        end else begin
          p.r0 = mk_err(ER_HEX);
          p.next = M_ERR;
        end
      end
      M_ERR: ;
      default: ;
    endcase
    return p;
  endfunction

  mode_e                mode_q, mode_d;
  logic [3:0]           hex_q, hex_d;
  logic [LineBits-1:0]  line_q;
  logic                 line_inc;
  pass_t [2:0]          pl;
  logic  [2:0]          act;
  res_t  [MAX_RES-1:0]  slot;
  logic  [1:0]          cnt;
  logic  [LineBits+LINE_OUT_W-1:0] line_wide;

  always_comb begin
    pl[0] = scan_pass(mode_q, byte_i, hex_q);
    pl[1] = scan_pass(pl[0].next, byte_i, pl[0].hex);
    pl[2] = scan_pass(pl[1].next, byte_i, pl[1].hex);
    act[0] = 1'b1;
    act[1] = pl[0].again;
    act[2] = pl[0].again & pl[1].again;
    slot = {MAX_RES{mk_end(TK_STR)}};
    cnt = 2'd0;
    mode_d = pl[0].next;
    hex_d = pl[0].hex;
    line_inc = 1'b0;
    if (eoi_i) begin
      mode_d = M_IDLE;
      hex_d = 4'h0;
      unique case (mode_q)
        M_IDLE, M_COMMENT: begin
          slot[0] = mk_end(TK_EOF); cnt = 2'd1;
        end
        M_NAME: begin
          slot[0] = mk_end(TK_NAME); slot[1] = mk_end(TK_EOF); cnt = 2'd2;
        end
        M_STR: begin
          slot[0] = mk_end(TK_STR); slot[1] = mk_end(TK_EOF); cnt = 2'd2;
        end
        M_NUM1, M_NUM3, M_NUM5: begin
          slot[0] = mk_end(TK_NUMBER); slot[1] = mk_end(TK_EOF); cnt = 2'd2;
        end
        M_NUM2, M_NUM4: begin
          slot[0] = mk_err(ER_NUMBER); cnt = 2'd1;
        end
        M_MINUS: begin
          slot[0] = mk_text(TK_STR, "-");
          slot[1] = mk_end(TK_STR);
          slot[2] = mk_end(TK_EOF);
          cnt = 2'd3;
        end
        M_QSTR, M_QESC: begin
          slot[0] = mk_err(ER_UNTERM); cnt = 2'd1;
        end
        M_HEX1, M_HEX2: begin
          slot[0] = mk_err(ER_HEX); cnt = 2'd1;
        end
        M_ERR: ;
        default: ;
      endcase
    end else begin
      for (int i = 0; i < 3; i++) begin
        if (act[i]) begin
          mode_d = pl[i].next;
          hex_d = pl[i].hex;
          line_inc = line_inc | pl[i].line_inc;
          if ((pl[i].n != 2'd0) && (cnt != 2'd3)) begin
            slot[cnt] = pl[i].r0;
            cnt = cnt + 2'd1;
          end
          if ((pl[i].n == 2'd2) && (cnt != 2'd3)) begin
            slot[cnt] = pl[i].r1;
            cnt = cnt + 2'd1;
          end
        end
      end
    end
  end

  assign line_wide     = {{LINE_OUT_W{1'b0}}, line_q};
  assign batch_o.cnt   = cnt;
  assign batch_o.res   = slot;
  assign batch_o.line  = line_wide[LINE_OUT_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_IDLE;
      hex_q  <= 4'h0;
      line_q <= {{(LineBits-1){1'b0}}, 1'b1};
    end else if (fire_i) begin
      mode_q <= mode_d;
      hex_q  <= hex_d;
      if (eoi_i) begin
        line_q <= {{(LineBits-1){1'b0}}, 1'b1};
      end else if (line_inc && !(&line_q)) begin
        line_q <= line_q + {{(LineBits-1){1'b0}}, 1'b1};
      end
    end
  end

endmodule

// File: rtl/ctt_outbuf.sv
module ctt_outbuf import ctt_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  load_i,
  input  batch_t                batch_i,
  output logic                  ready_o,
  input  logic                  m_ready_i,
  output logic                  m_valid_o,
  output res_t                  m_res_o,
  output logic [LINE_OUT_W-1:0] m_line_o,
  output logic                  m_last_o
);

  res_t [MAX_RES-1:0]    res_q;
  logic [LINE_OUT_W-1:0] line_q;
  logic [1:0]            count_q;
  logic [1:0]            idx_q;
  logic                  fire;
  logic                  drained;

  assign m_valid_o = (count_q != 2'd0);
  assign m_last_o  = (idx_q == (count_q - 2'd1));
  assign m_res_o   = res_q[idx_q];
  assign m_line_o  = line_q;
  assign fire      = m_valid_o & m_ready_i;
  assign drained   = fire & m_last_o;
  assign ready_o   = (count_q == 2'd0) | drained;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 2'd0;
      idx_q   <= 2'd0;
    end else if (load_i) begin
      count_q <= batch_i.cnt;
      idx_q   <= 2'd0;
    end else if (drained) begin
      count_q <= 2'd0;
      idx_q   <= 2'd0;
    end else if (fire) begin
      idx_q <= idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q  <= batch_i.res;
      line_q <= batch_i.line;
    end
  end

endmodule

// File: rtl/config_text_tokenizer.sv
// Channel   Direction  tdata                                  tuser / tlast
// s_axis    in         [7:0] text byte                        tlast: end of input
// m_axis    out        [7:0] text byte, [10:8] error code,    tuser [1:0] result kind,
//                      [26:11] line number, [31:27] zero      [5:2] token kind; tlast: last
//
// A request is decoded in the cycle it is accepted and gives up to three results.
// Results leave one per cycle from a result buffer while the master side is ready,
// so a request giving at most one result is taken every cycle.
// Reset returns the scanner to idle at line one and empties the result buffer.
// A stall on the master side holds the buffer; a new request is taken as its last
// result leaves.
module config_text_tokenizer import ctt_pkg::*; #(
  parameter int unsigned LineBits = LINE_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] text_byte_in
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [7:0] text_byte_out, [10:8] error_code,
                                        // [26:11] line_number, [31:27] zero
  output logic [5:0]  m_axis_tuser_o,   // [1:0] result_kind, [5:2] token_kind
  output logic        m_axis_tlast_o
);

  logic                  in_fire;
  batch_t                batch;
  res_t                  res;
  logic [LINE_OUT_W-1:0] line;

  assign in_fire = s_axis_tvalid_i & s_axis_tready_o;

  ctt_scan #(
    .LineBits(LineBits)
  ) u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (in_fire),
    .byte_i (s_axis_tdata_i),
    .eoi_i  (s_axis_tlast_i),
    .batch_o(batch)
  );

  ctt_outbuf u_outbuf (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (in_fire),
    .batch_i  (batch),
    .ready_o  (s_axis_tready_o),
    .m_ready_i(m_axis_tready_i),
    .m_valid_o(m_axis_tvalid_o),
    .m_res_o  (res),
    .m_line_o (line),
    .m_last_o (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {5'd0, line, res.err, res.data};
  assign m_axis_tuser_o = {res.tok, res.kind};

endmodule

// File: rtl/ctt_checker.sv
`include "config_text_tokenizer_macros.svh"

module ctt_checker import ctt_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [31:0] m_axis_tdata_o,
  input logic [5:0]  m_axis_tuser_o,
  input logic        m_axis_tlast_o
);

  `CTT_ASSERT_NEXT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i,
    m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o)
    && $stable(m_axis_tlast_o), "stalled result changed")

  `CTT_ASSERT_NOW(a_err_last, m_axis_tvalid_o && (m_axis_tuser_o[1:0] == RK_ERROR),
    m_axis_tlast_o && (m_axis_tuser_o[5:2] == TK_STR) && (m_axis_tdata_o[7:0] == 8'h00)
    && (m_axis_tdata_o[10:8] != ER_NONE), "malformed error result")

  `CTT_ASSERT_NOW(a_eof_last, m_axis_tvalid_o && (m_axis_tuser_o[1:0] == RK_END)
    && (m_axis_tuser_o[5:2] == TK_EOF), m_axis_tlast_o, "eof is not the last result")

  `CTT_ASSERT_NOW(a_no_take_busy, s_axis_tready_o && m_axis_tvalid_o,
    m_axis_tready_i && m_axis_tlast_o, "request taken while results still pending")

endmodule

bind config_text_tokenizer ctt_checker u_ctt_checker (.*);
